// ----- hdl/wsdm_pkg.sv -----
// Shared types, constants and helpers for the weighted state distance metric.
`timescale 1ns / 1ps
`default_nettype none
package wsdm_pkg;

   localparam int PI_RAW     = 205887;
   localparam int TWO_PI_RAW = 411775;
   localparam logic [31:0] INV_HALF_PI_K = 32'd2734261102;
   localparam logic [33:0] EDGE_RADIUS   = 34'd32768;
   localparam logic [33:0] NEAR_RADIUS   = 34'd19661;
   localparam logic [16:0] ONE_RAW       = 17'd65536;
   localparam int SQRT_STAGES = 32;

   typedef enum logic [2:0] {
      CSR_GOAL_X    = 3'd0,
      CSR_GOAL_Y    = 3'd1,
      CSR_GOAL_HEAD = 3'd2,
      CSR_GOAL_LIN  = 3'd3,
      CSR_GOAL_ROT  = 3'd4
   } csr_index_type;

   // squared distance: low 64 bits of the sum and its carry
   typedef struct packed {
      logic [63:0] sum;
      logic        ovf;
   } sq_type;

   // per-item values that ride alongside the square roots
   typedef struct packed {
      logic        nearest;
      logic        coin;
      logic [17:0] ang_m;
      logic [17:0] ang_r;
      logic [33:0] s_to;
      logic [33:0] s_goal;
   } side_type;

   // |heading difference| wrapped into [-pi, pi]; one fold covers the input range
   function automatic logic [17:0] wrap_abs(input logic signed [19:0] d);
      logic signed [20:0] w;
      w = 21'(d);
      if (w > 21'(PI_RAW)) begin
         w = w - 21'(TWO_PI_RAW);
      end else if (w < -21'(PI_RAW)) begin
         w = w + 21'(TWO_PI_RAW);
      end
      if (w < 0) begin
         w = -w;
      end
      return w[17:0];
   endfunction

   // magnitude of a 33-bit signed difference
   function automatic logic [32:0] abs33(input logic [32:0] d);
      return d[32] ? 33'(-d) : d;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/weighted_state_distance_metric_top.sv -----
// Top level of the weighted state distance metric pipeline.
//
// Weighted planner distance between two robot states, Q16.16 throughout.
// One beat is accepted every cycle whenever the result side keeps up; each
// request beat yields exactly one response beat after 3 front-end stages
// for differences, squares and angle scaling, 32 square-root stages, 2 stages
// for the goal-radius test and speed weighting, and 1 output register.
// The 32-stage square root, one result bit per stage, is the deepest part.
// When the response is held off the whole pipeline freezes in place.
// The user must write goal registers through the csr port only while the pipe is empty; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
module weighted_state_distance_metric_top
   import wsdm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   // request
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // from_x, from_y, from_heading, from_lin_speed, from_rot_speed, to_x, to_y,
   // to_heading, to_lin_speed, to_rot_speed, coin, one zero pad bit
   input  wire logic [295:0] req_tdata,
   input  wire logic         req_tuser,    // req_type
   // response
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [31:0]       rsp_tdata,    // metric
   output logic              rsp_tuser,    // goal_speed_used
   // goal registers
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [2:0]   csr_index,
   input  wire logic [31:0]  csr_data
);

   localparam int VLD_DEPTH = 3 + SQRT_STAGES + 2;

   // goal registers
   logic signed [31:0] goal_x_ff, goal_y_ff, goal_lin_ff, goal_rot_ff;
   logic signed [18:0] goal_head_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_x_ff    <= '0;
         goal_y_ff    <= '0;
         goal_head_ff <= '0;
         goal_lin_ff  <= '0;
         goal_rot_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_GOAL_X:    goal_x_ff    <= csr_data;
            CSR_GOAL_Y:    goal_y_ff    <= csr_data;
            CSR_GOAL_HEAD: goal_head_ff <= csr_data[18:0];
            CSR_GOAL_LIN:  goal_lin_ff  <= csr_data;
            CSR_GOAL_ROT:  goal_rot_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // global advance: every stage moves when the output slot is free or drains
   logic adv;
   logic rsp_valid_ff;
   logic [VLD_DEPTH-1:0] vld_ff;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[VLD_DEPTH-2:0], req_tvalid};
         rsp_valid_ff <= vld_ff[VLD_DEPTH-1];
      end
   end

   // front end
   sq_type   m_sq, r_sq;
   side_type side_s3;

   wsdm_prep u_prep (
      .clock          (clock),
      .adv            (adv),
      .nearest        (req_tuser),
      .coin           (req_tdata[294]),
      .from_x         (req_tdata[31:0]),
      .from_y         (req_tdata[63:32]),
      .from_heading   (req_tdata[82:64]),
      .from_lin_speed (req_tdata[114:83]),
      .from_rot_speed (req_tdata[146:115]),
      .to_x           (req_tdata[178:147]),
      .to_y           (req_tdata[210:179]),
      .to_heading     (req_tdata[229:211]),
      .to_lin_speed   (req_tdata[261:230]),
      .to_rot_speed   (req_tdata[293:262]),
      .goal_x         (goal_x_ff),
      .goal_y         (goal_y_ff),
      .goal_heading   (goal_head_ff),
      .goal_lin_speed (goal_lin_ff),
      .goal_rot_speed (goal_rot_ff),
      .m_sq           (m_sq),
      .r_sq           (r_sq),
      .side           (side_s3)
   );

   // square roots: metric distance and goal distance side by side
   logic [32:0] mdist, rdist;

   wsdm_isqrt u_sqrt_m (.clock(clock), .adv(adv), .sq_i(m_sq), .dist_o(mdist));
   wsdm_isqrt u_sqrt_r (.clock(clock), .adv(adv), .sq_i(r_sq), .dist_o(rdist));

   // sideband delay line matching the root pipeline
   side_type side_ff [0:SQRT_STAGES-1];

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= side_s3;
         for (int i = 1; i < SQRT_STAGES; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   side_type sd;
   assign sd = side_ff[SQRT_STAGES-1];

   // radius stage: r against the metric's limit, pick speed sum
   logic [33:0] r_in, lim_in;
   logic        near_in, use_in;
   logic        near_ff, use_ff, nearest_r_ff;
   logic [33:0] ssel_ff, base_ff;
   logic [16:0] wmul_ff;

   always_comb begin
      r_in    = 34'(rdist) + 34'(sd.ang_r);
      lim_in  = sd.nearest ? NEAR_RADIUS : EDGE_RADIUS;
      near_in = r_in < lim_in;
      use_in  = sd.nearest && near_in && sd.coin;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         near_ff      <= near_in;
         use_ff       <= use_in;
         nearest_r_ff <= sd.nearest;
         ssel_ff      <= use_in ? sd.s_goal : sd.s_to;
         wmul_ff      <= ONE_RAW - r_in[16:0];   // only meaningful inside the radius
         base_ff      <= 34'(mdist) + 34'(sd.ang_m);
      end
   end

   // weight stage: (1 - r) * s inside the radius, s / 2 outside
   logic [50:0] wprod;
   logic [34:0] weight_ff;
   logic [33:0] base2_ff;
   logic        use2_ff;

   assign wprod = 51'(wmul_ff) * 51'(ssel_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         weight_ff <= near_ff ? wprod[50:16] : 35'(ssel_ff[33:1]);
         base2_ff  <= base_ff;
         use2_ff   <= use_ff;
      end
   end

   // output register with saturation
   logic [35:0] total;
   logic [31:0] metric_ff;
   logic        used_ff;

   assign total = 36'(base2_ff) + 36'(weight_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         metric_ff <= (total[35:32] != 4'd0) ? 32'hFFFF_FFFF : total[31:0];
         used_ff   <= use2_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = metric_ff;
   assign rsp_tuser  = used_ff;

`ifndef SYNTH
   // a frozen pipe keeps its occupancy
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("valid pipeline moved during stall");

   // goal speeds only ever replace for the nearest-node metric
   a_use_nearest: assert property (@(posedge clock) disable iff (reset)
      use_ff |-> nearest_r_ff && near_ff)
      else $error("goal speeds used outside nearest-node radius");

   // inside either radius the weight factor stays above one half
   a_wmul_range: assert property (@(posedge clock) disable iff (reset)
      near_ff |-> (wmul_ff > 17'd32768))
      else $error("near weight factor out of range");

   // result becomes valid exactly one advance after the last stage held an item
   a_out_follow: assert property (@(posedge clock) disable iff (reset)
      adv |=> (rsp_valid_ff == $past(vld_ff[VLD_DEPTH-1])))
      else $error("output valid out of step with pipeline");
`endif

endmodule
`default_nettype wire

// ----- hdl/wsdm_prep.sv -----
// Front end: differences, squares and angle scaling over three stages.
`timescale 1ns / 1ps
`default_nettype none
module wsdm_prep
   import wsdm_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               adv,
   input  wire logic               nearest,
   input  wire logic               coin,
   input  wire logic signed [31:0] from_x,
   input  wire logic signed [31:0] from_y,
   input  wire logic signed [18:0] from_heading,
   input  wire logic signed [31:0] from_lin_speed,
   input  wire logic signed [31:0] from_rot_speed,
   input  wire logic signed [31:0] to_x,
   input  wire logic signed [31:0] to_y,
   input  wire logic signed [18:0] to_heading,
   input  wire logic signed [31:0] to_lin_speed,
   input  wire logic signed [31:0] to_rot_speed,
   input  wire logic signed [31:0] goal_x,
   input  wire logic signed [31:0] goal_y,
   input  wire logic signed [18:0] goal_heading,
   input  wire logic signed [31:0] goal_lin_speed,
   input  wire logic signed [31:0] goal_rot_speed,
   output sq_type                  m_sq,
   output sq_type                  r_sq,
   output side_type                side
);

   // stage 1
   logic [32:0] mdx_in, mdy_in, rdx_in, rdy_in;
   logic [32:0] dv_in, dw_in, gv_in, gw_in;
   logic [17:0] ang_m_in, ang_r_in;
   logic signed [19:0] dh_m, dh_r;
   logic [32:0] mdx_ff, mdy_ff, rdx_ff, rdy_ff;
   logic [32:0] dv_ff, dw_ff, gv_ff, gw_ff;
   logic [17:0] ang_m_ff, ang_r_ff;
   logic        nearest1_ff, coin1_ff;

   always_comb begin
      logic signed [31:0] rx, ry;
      rx = nearest ? from_x : to_x;
      ry = nearest ? from_y : to_y;
      mdx_in = abs33(33'(to_x) - 33'(from_x));
      mdy_in = abs33(33'(to_y) - 33'(from_y));
      rdx_in = abs33(33'(goal_x) - 33'(rx));
      rdy_in = abs33(33'(goal_y) - 33'(ry));
      dv_in  = abs33(33'(to_lin_speed) - 33'(from_lin_speed));
      dw_in  = abs33(33'(to_rot_speed) - 33'(from_rot_speed));
      gv_in  = abs33(33'(goal_lin_speed) - 33'(from_lin_speed));
      gw_in  = abs33(33'(goal_rot_speed) - 33'(from_rot_speed));
      dh_m   = 20'(to_heading) - 20'(from_heading);
      dh_r   = 20'(goal_heading) - 20'(to_heading);
      ang_m_in = wrap_abs(dh_m);
      ang_r_in = nearest ? ang_m_in : wrap_abs(dh_r);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mdx_ff <= mdx_in;  mdy_ff <= mdy_in;
         rdx_ff <= rdx_in;  rdy_ff <= rdy_in;
         dv_ff  <= dv_in;   dw_ff  <= dw_in;
         gv_ff  <= gv_in;   gw_ff  <= gw_in;
         ang_m_ff <= ang_m_in;
         ang_r_ff <= ang_r_in;
         nearest1_ff <= nearest;
         coin1_ff    <= coin;
      end
   end

   // stage 2: squares wrap modulo 2^64 (a magnitude of 2^32 squares to zero)
   function automatic logic [63:0] sq64(input logic [32:0] m);
      return m[32] ? 64'd0 : 64'(m[31:0]) * 64'(m[31:0]);
   endfunction

   logic [63:0] msx_ff, msy_ff, rsx_ff, rsy_ff;
   logic [49:0] pm_ff, pr_ff;
   logic [33:0] s_to2_ff, s_goal2_ff;
   logic        nearest2_ff, coin2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         msx_ff <= sq64(mdx_ff);
         msy_ff <= sq64(mdy_ff);
         rsx_ff <= sq64(rdx_ff);
         rsy_ff <= sq64(rdy_ff);
         pm_ff  <= 50'(ang_m_ff) * 50'(INV_HALF_PI_K);
         pr_ff  <= 50'(ang_r_ff) * 50'(INV_HALF_PI_K);
         s_to2_ff   <= 34'(dv_ff) + 34'(dw_ff);
         s_goal2_ff <= 34'(gv_ff) + 34'(gw_ff);
         nearest2_ff <= nearest1_ff;
         coin2_ff    <= coin1_ff;
      end
   end

   // stage 3: sums with carry, angle rounding
   logic [64:0] m_sum_in, r_sum_in;
   logic [49:0] pm_rnd, pr_rnd;
   sq_type   m_sq_ff, r_sq_ff;
   side_type side_ff;

   always_comb begin
      m_sum_in = 65'(msx_ff) + 65'(msy_ff);
      r_sum_in = 65'(rsx_ff) + 65'(rsy_ff);
      pm_rnd   = pm_ff + 50'h0_8000_0000;
      pr_rnd   = pr_ff + 50'h0_8000_0000;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_sq_ff.sum <= m_sum_in[63:0];
         m_sq_ff.ovf <= m_sum_in[64];
         r_sq_ff.sum <= r_sum_in[63:0];
         r_sq_ff.ovf <= r_sum_in[64];
         side_ff.nearest <= nearest2_ff;
         side_ff.coin    <= coin2_ff;
         side_ff.ang_m   <= pm_rnd[49:32];
         side_ff.ang_r   <= pr_rnd[49:32];
         side_ff.s_to    <= s_to2_ff;
         side_ff.s_goal  <= s_goal2_ff;
      end
   end

   assign m_sq = m_sq_ff;
   assign r_sq = r_sq_ff;
   assign side = side_ff;

endmodule
`default_nettype wire

// ----- hdl/wsdm_isqrt.sv -----
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module wsdm_isqrt
   import wsdm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        adv,
   input  sq_type           sq_i,
   output logic [32:0]      dist_o
);

   logic [63:0] op_ff  [0:SQRT_STAGES-1];
   logic [63:0] res_ff [0:SQRT_STAGES-1];
   logic        ovf_ff [0:SQRT_STAGES-1];

   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
      logic [63:0] op_src, res_src, trial;
      logic        ovf_src;

      if (k == 0) begin : g_first
         assign op_src  = sq_i.sum;
         assign res_src = 64'd0;
         assign ovf_src = sq_i.ovf;
      end else begin : g_next
         assign op_src  = op_ff[k-1];
         assign res_src = res_ff[k-1];
         assign ovf_src = ovf_ff[k-1];
      end

      assign trial = res_src + BIT;

      always_ff @(posedge clock) begin
         if (adv) begin
            if (op_src >= trial) begin
               op_ff[k]  <= op_src - trial;
               res_ff[k] <= (res_src >> 1) + BIT;
            end else begin
               op_ff[k]  <= op_src;
               res_ff[k] <= res_src >> 1;
            end
            ovf_ff[k] <= ovf_src;
         end
      end
   end

   // an overflowed square reads as 2^32
   assign dist_o = ovf_ff[SQRT_STAGES-1] ? 33'h1_0000_0000
                                         : {1'b0, res_ff[SQRT_STAGES-1][31:0]};

endmodule
`default_nettype wire

// ----- test/weighted_state_distance_metric_top_tb.sv -----
// Self-checking testbench for the weighted state distance metric top level.
`timescale 1ns / 1ps
module weighted_state_distance_metric_top_tb;
   import wsdm_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 60;   // pipe is 38 deep
   localparam int PHASE_ITEMS = 150;

   // one request: two robot states plus selector and coin
   typedef struct {
      bit              nearest;
      bit signed [31:0] fx, fy, fv, fw;
      bit signed [18:0] fh;
      bit signed [31:0] tx, ty, tv, tw;
      bit signed [18:0] th;
      bit              coin;
   } state_pair_type;

   typedef struct {
      bit [31:0] metric;
      bit        goal_used;
   } metric_beat_type;

   // Golden metric calculator plus queue of pending metrics.
   class metric_scoreboard;
      bit signed [31:0] goal_x, goal_y, goal_v, goal_w;
      bit signed [18:0] goal_h;
      metric_beat_type  pending[$];
      int               mismatches;

      function void set_goal(csr_index_type idx, bit [31:0] data);
         case (idx)
            CSR_GOAL_X:    goal_x = data;
            CSR_GOAL_Y:    goal_y = data;
            CSR_GOAL_HEAD: goal_h = data[18:0];
            CSR_GOAL_LIN:  goal_v = data;
            CSR_GOAL_ROT:  goal_w = data;
            default: ;
         endcase
      endfunction

      function bit [63:0] int_sqrt(bit [63:0] op);
         bit [63:0] res, b;
         res = 0;
         b = 64'd1 << 62;
         while (b > op) b = b >> 2;
         while (b != 0) begin
            if (op >= res + b) begin
               op = op - (res + b);
               res = (res >> 1) + b;
            end else begin
               res = res >> 1;
            end
            b = b >> 2;
         end
         return res;
      endfunction

      // Euclidean distance; squares wrap at 64 bits, a carried sum means 2^32
      function bit [63:0] planar(longint dx, longint dy);
         bit [63:0] ax, ay, a, b, s;
         ax = (dx < 0) ? -dx : dx;
         ay = (dy < 0) ? -dy : dy;
         a = ax * ax;
         b = ay * ay;
         s = a + b;
         if (s < a) return 64'd1 << 32;
         return int_sqrt(s);
      endfunction

      // |wrapped heading difference| * 2/pi, rounded
      function bit [63:0] heading_cost(longint d);
         bit [63:0] a, p;
         while (d > PI_RAW) d = d - TWO_PI_RAW;
         while (d < -PI_RAW) d = d + TWO_PI_RAW;
         a = (d < 0) ? -d : d;
         p = a * 64'(INV_HALF_PI_K) + (64'd1 << 31);
         return p >> 32;
      endfunction

      function void note_request(state_pair_type it);
         longint tv, tw;
         bit [63:0] ang, r, lim, s, total;
         metric_beat_type m;
         tv = it.tv;
         tw = it.tw;
         m.goal_used = 0;
         ang = heading_cost(longint'(it.th) - longint'(it.fh));
         if (it.nearest) begin
            r = planar(longint'(goal_x) - it.fx, longint'(goal_y) - it.fy) + ang;
            lim = NEAR_RADIUS;
            if (r < lim && it.coin) begin
               tv = goal_v;
               tw = goal_w;
               m.goal_used = 1;
            end
         end else begin
            r = planar(longint'(goal_x) - it.tx, longint'(goal_y) - it.ty)
                + heading_cost(longint'(goal_h) - longint'(it.th));
            lim = EDGE_RADIUS;
         end
         s = ((tv - it.fv) < 0 ? -(tv - it.fv) : (tv - it.fv))
           + ((tw - it.fw) < 0 ? -(tw - it.fw) : (tw - it.fw));
         total = planar(longint'(it.tx) - it.fx, longint'(it.ty) - it.fy) + ang
               + ((r < lim) ? (((64'd65536 - r) * s) >> 16) : (s >> 1));
         m.metric = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
         pending.push_back(m);
      endfunction

      function void check_beat(bit [31:0] metric, bit goal_used);
         metric_beat_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected beat: metric=%h used=%b", metric, goal_used);
            return;
         end
         e = pending.pop_front();
         if (e.metric !== metric || e.goal_used !== goal_used) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: metric exp %h got %h, used exp %b got %b",
                        e.metric, metric, e.goal_used, goal_used);
         end
      endfunction
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [295:0] req_tdata = '0;
   logic         req_tuser = 0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [31:0]  rsp_tdata;
   logic         rsp_tuser;
   logic         csr_valid = 0;
   logic         csr_ready;
   logic [2:0]   csr_index = '0;
   logic [31:0]  csr_data = '0;

   metric_scoreboard sb = new();
   bit no_idle = 0;      // phases without gaps or stalls
   bit rsp_took = 0;
   int cycles = 0;

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   weighted_state_distance_metric_top u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_beat(rsp_tdata, rsp_tuser);
         rsp_took = 1;
      end
   end

   // result back-pressure: fresh stall drawn after every beat
   int stall = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready = 0;
      end else begin
         if (rsp_took) begin
            rsp_took = 0;
            stall = no_idle ? 0 : $urandom_range(0, 17);
         end
         if (stall > 0) begin
            rsp_tready = 0;
            stall--;
         end else begin
            rsp_tready = 1;
         end
      end
   end

   function automatic bit signed [18:0] clamp_heading(int h);
      if (h > PI_RAW) return 19'(PI_RAW);
      if (h < -PI_RAW) return -19'(PI_RAW);
      return 19'(h);
   endfunction

   function automatic bit signed [18:0] any_heading();
      return clamp_heading(int'($urandom_range(0, 2 * PI_RAW)) - PI_RAW);
   endfunction

   function automatic bit signed [31:0] jitter(int span);
      return 32'(int'($urandom_range(0, 2 * span)) - span);
   endfunction

   // Called at a falling edge; returns at the falling edge after the beat.
   task automatic send_request(state_pair_type it);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_tvalid = 0;
         repeat (gap) @(negedge clock);
      end
      req_tuser = it.nearest;
      req_tdata = {1'b0, it.coin, it.tw, it.tv, it.th, it.ty, it.tx,
                   it.fw, it.fv, it.fh, it.fy, it.fx};
      req_tvalid = 1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(it);
      @(negedge clock);
   endtask

   task automatic write_goal(csr_index_type idx, bit [31:0] data);
      req_tvalid = 0;
      csr_index = idx;
      csr_data = data;
      csr_valid = 1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_goal(idx, data);
      @(negedge clock);
      csr_valid = 0;
   endtask

   task automatic wait_idle();
      req_tvalid = 0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // random request: half of the states near the goal so both weightings fire
   function automatic state_pair_type random_request();
      state_pair_type it;
      int kind;
      kind = $urandom_range(0, 3);
      it.nearest = $urandom_range(0, 1);
      it.coin = $urandom_range(0, 1);
      it.fx = $urandom; it.fy = $urandom; it.fv = $urandom; it.fw = $urandom;
      it.tx = $urandom; it.ty = $urandom; it.tv = $urandom; it.tw = $urandom;
      it.fh = any_heading();
      it.th = any_heading();
      case (kind)
         1: begin
            it.nearest = 1;
            it.fx = sb.goal_x + jitter(15000);
            it.fy = sb.goal_y + jitter(15000);
            it.th = clamp_heading(int'(it.fh) + int'(jitter(6000)));
            it.tx = it.fx + jitter(200000);
            it.ty = it.fy + jitter(200000);
         end
         2: begin
            it.nearest = 0;
            it.tx = sb.goal_x + jitter(25000);
            it.ty = sb.goal_y + jitter(25000);
            it.th = clamp_heading(int'(sb.goal_h) + int'(jitter(10000)));
            it.fx = it.tx + jitter(200000);
            it.fy = it.ty + jitter(200000);
         end
         3: begin
            it.fx = jitter(1 << 20); it.fy = jitter(1 << 20);
            it.tx = jitter(1 << 20); it.ty = jitter(1 << 20);
            it.fv = jitter(1 << 18); it.tv = jitter(1 << 18);
         end
         default: ;
      endcase
      return it;
   endfunction

   function automatic state_pair_type at_rest(bit nearest, bit coin);
      state_pair_type it;
      it = '{nearest, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, coin};
      return it;
   endfunction

   initial begin
      state_pair_type it;
      bit [31:0] goal_sets[5][5];
      goal_sets[0] = '{32'h0001_8000, 32'hFFFF_4000, 32'h0001_0000, 32'h0000_8000,
                       32'hFFFF_0000};
      goal_sets[1] = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'(PI_RAW), 32'h7FFF_FFFF,
                       32'h7FFF_FFFF};
      goal_sets[2] = '{32'h8000_0000, 32'h8000_0000, 32'(-PI_RAW), 32'h8000_0000,
                       32'h8000_0000};
      goal_sets[3] = '{$urandom, $urandom, 32'(any_heading()), $urandom, $urandom};
      goal_sets[4] = '{0, 0, 0, 0, 0};

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: goal at the origin
      send_request(at_rest(0, 0));
      send_request(at_rest(1, 1));            // on the goal, coin set: goal speeds swap in
      send_request(at_rest(1, 0));            // on the goal, coin clear
      it = at_rest(1, 1); it.tv = 32'h7FFF_FFFF; it.tw = 32'h8000_0000;
      it.fv = 32'h8000_0000; it.fw = 32'h7FFF_FFFF;
      send_request(it);
      it = at_rest(0, 1); it.tv = 32'h7FFF_FFFF; it.fv = 32'h8000_0000;
      it.tw = 32'h8000_0000; it.fw = 32'h7FFF_FFFF;
      send_request(it);                       // edge metric near goal, huge speed gap
      it = at_rest(0, 0); it.fx = 32'h8000_0000; it.tx = 32'h7FFF_FFFF;
      send_request(it);                       // widest x span
      it.fy = 32'h8000_0000; it.ty = 32'h7FFF_FFFF;
      send_request(it);                       // squared sum overflows
      it.nearest = 1; it.coin = 1;
      send_request(it);
      it = at_rest(0, 0); it.fh = -19'(PI_RAW); it.th = 19'(PI_RAW);
      send_request(it);                       // heading wrap at +-pi
      it.fh = 19'(PI_RAW); it.th = -19'(PI_RAW); it.nearest = 1;
      send_request(it);
      it = at_rest(1, 1); it.fx = 32'd19660;
      send_request(it);                       // just inside the nearest radius
      it.fx = 32'd19661;
      send_request(it);                       // exactly on it
      it = at_rest(0, 0); it.tx = 32'd32767; it.fv = 32'd65536;
      send_request(it);
      it.tx = 32'd32768;
      send_request(it);                       // edge radius boundary
      it = at_rest(1, 0); it.fx = 32'hFFFF_FFFF; it.fy = 32'hFFFF_FFFF;
      it.fv = 32'hFFFF_FFFF; it.fw = 32'hFFFF_FFFF; it.fh = 19'h7FFFF;
      send_request(it);
      it.nearest = 0; it.tx = 32'hFFFF_FFFF; it.ty = 32'h7FFF_FFFF;
      it.tv = 32'h7FFF_FFFF; it.tw = 32'h7FFF_FFFF; it.th = -19'(PI_RAW);
      send_request(it);

      for (int ph = 0; ph < 5; ph++) begin
         wait_idle();
         for (int k = 0; k < 5; k++)
            write_goal(csr_index_type'(k), goal_sets[ph][k]);
         no_idle = (ph % 2 == 1);
         if (ph < 3) begin
            // on-goal probes against each new goal
            it = at_rest(1, 1);
            it.fx = sb.goal_x; it.fy = sb.goal_y; it.tx = sb.goal_x; it.ty = sb.goal_y;
            send_request(it);
            it.nearest = 0; it.th = sb.goal_h; it.fh = sb.goal_h;
            send_request(it);
         end
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_request(random_request());
      end

      wait_idle();
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
